### design/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
// Used by ffba_cell and first_fit_block_allocator_unit; no dependencies.
`default_nettype none
package ffba_pkg;

  // Field widths fixed by the pool's address space
  localparam int unsigned BYTE_W = 15;
  // Widest segment index and count that the broadcast bus carries
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned CNT_W  = 11;

  // Parameter defaults
  localparam int unsigned DEF_POOL_BYTES   = 32768;
  localparam int unsigned DEF_HEADER_BYTES = 40;
  localparam int unsigned DEF_MAX_SEGMENTS = 512;

  // Opcodes of an input transaction
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Actions broadcast to the row of cells
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;
  localparam logic [1:0] ACT_MERGE = 2'd3;

  // One segment entry
  typedef struct packed {
    logic [BYTE_W-1:0] start;
    logic [BYTE_W-1:0] size;
    logic              free;
  } seg_t;

  // Broadcast command from the controller to every cell
  typedef struct packed {
    logic [1:0]        act;
    logic              op;
    logic [BYTE_W-1:0] req;
    logic [BYTE_W-1:0] addr;
    logic [IDX_W-1:0]  w;
    logic [CNT_W-1:0]  cnt;
    logic              split;
    logic              merge;
  } cmd_t;

  // Status from one cell; all but hit are zero unless the cell is concerned
  typedef struct packed {
    logic              hit;
    logic              split_ok;
    logic              next_free;
    logic              prev_free;
    logic [BYTE_W-1:0] grant;
  } flags_t;

endpackage
`default_nettype wire

### design/ffba_cell.sv
// One segment cell of the allocator row: holds an entry, compares it with
// the broadcast request and shifts to or from its neighbours. Uses ffba_pkg.
`default_nettype none
module ffba_cell #(
  parameter int unsigned IDX          = 0,
  parameter int unsigned POOL_BYTES   = ffba_pkg::DEF_POOL_BYTES,
  parameter int unsigned HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ffba_pkg::cmd_t  cmd,
  input  wire ffba_pkg::seg_t  left,
  input  wire ffba_pkg::seg_t  right,
  output ffba_pkg::seg_t       seg,
  output ffba_pkg::flags_t     flags
);

  localparam logic [ffba_pkg::BYTE_W-1:0] HDR = ffba_pkg::BYTE_W'(HEADER_BYTES);

  logic valid, is_w, is_prev, above_w;
  logic [ffba_pkg::BYTE_W:0]   hdr_addr;
  logic [ffba_pkg::BYTE_W-1:0] rem;

  // Position relative to the selected entry
  assign valid   = ffba_pkg::CNT_W'(IDX) < cmd.cnt;
  assign is_w    = ffba_pkg::IDX_W'(IDX) == cmd.w;
  assign is_prev = ffba_pkg::CNT_W'(IDX + 1) == {1'b0, cmd.w};
  assign above_w = ffba_pkg::IDX_W'(IDX) > cmd.w;
  assign hdr_addr = {1'b0, seg.start} + {1'b0, HDR};
  assign rem      = seg.size - cmd.req;

  // Match and neighbour status
  always_comb begin
    flags.hit       = valid && ((cmd.op == ffba_pkg::OP_FREE) ?
                      (hdr_addr == {1'b0, cmd.addr}) :
                      (seg.free && (seg.size >= cmd.req)));
    flags.split_ok  = is_w && (rem > HDR);
    flags.next_free = is_w && (ffba_pkg::CNT_W'(IDX + 1) < cmd.cnt) && right.free;
    flags.prev_free = is_prev && seg.free;
    flags.grant     = is_w ? hdr_addr[ffba_pkg::BYTE_W-1:0] : '0;
  end

  // Entry update
  always_ff @(posedge clk) begin
    if (rst) begin
      seg.free <= (IDX == 0);
      if (IDX == 0) begin
        seg.start <= '0;
        seg.size  <= ffba_pkg::BYTE_W'(POOL_BYTES - HEADER_BYTES);
      end
    end else begin
      case (cmd.act)
        ffba_pkg::ACT_ALLOC: begin
          if (is_w) begin
            seg.free <= 1'b0;
            if (cmd.split) seg.size <= cmd.req;
          end else if (cmd.split && ffba_pkg::CNT_W'(IDX) == {1'b0, cmd.w} + 1'b1) begin
            seg.start <= left.start + HDR + cmd.req;
            seg.size  <= left.size - cmd.req - HDR;
            seg.free  <= 1'b1;
          end else if (cmd.split && above_w) begin
            seg <= left;
          end
        end
        ffba_pkg::ACT_FREE: begin
          if (is_w) begin
            seg.free <= 1'b1;
            if (cmd.merge) seg.size <= seg.size + right.size + HDR;
          end else if (cmd.merge && above_w) begin
            seg <= right;
          end
        end
        ffba_pkg::ACT_MERGE: begin
          if (cmd.merge && is_prev) begin
            seg.size <= seg.size + right.size + HDR;
          end else if (cmd.merge && (is_w || above_w)) begin
            seg <= right;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### design/first_fit_block_allocator_unit.sv
// First-fit block allocator: top level with controller and row of cells.
// Depends on ffba_pkg and ffba_cell.
//
// Input channel (in_valid/in_stall): opcode, request_size, block_address.
// Output channel (out_valid/out_stall): success, granted_address, one result
// transaction for every input transaction.
// Every segment sits in a cell of a row; all cells compare against the
// request in parallel, a two-stage registered priority tree picks the first
// match, and the row then splits, marks or shifts. Each transaction passes
// look, pick and act; the result is written in the cycle the row updates.
// One transaction is in work at a time; in_stall is high from acceptance
// until the controller is idle again, and a found free also passes a
// merge step for its previous neighbour.
// The result register frees the input side: a new item is accepted while
// the previous result waits; if the receiver stalls, the next item waits
// at its pick stage until the result register drains.
// Reset (synchronous) leaves one free segment spanning the whole pool and
// an empty result register; no clearing pass is needed.
`default_nettype none
module first_fit_block_allocator_unit #(
  parameter int unsigned POOL_BYTES   = ffba_pkg::DEF_POOL_BYTES,
  parameter int unsigned HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES,
  parameter int unsigned MAX_SEGMENTS = ffba_pkg::DEF_MAX_SEGMENTS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        opcode,
  input  wire logic [ffba_pkg::BYTE_W-1:0] request_size,
  input  wire logic [ffba_pkg::BYTE_W-1:0] block_address,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             success,
  output logic [ffba_pkg::BYTE_W-1:0]      granted_address
);

  localparam int unsigned IW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CW  = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned GS  = 32;
  localparam int unsigned NG  = (MAX_SEGMENTS + GS - 1) / GS;
  localparam int unsigned GW  = $clog2(GS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_ACT   = 3'd3;
  localparam logic [2:0] S_MERGE = 3'd4;

  logic [2:0]                  state;
  logic                        op;
  logic [ffba_pkg::BYTE_W-1:0] req, addr;
  logic [CW-1:0]               cnt;
  logic [IW-1:0]               w, w_next;
  logic                        found, found_next;
  logic [NG-1:0]               grp_any, grp_any_next;
  logic [GW-1:0]               grp_idx [NG];
  logic [GW-1:0]               grp_idx_next [NG];

  ffba_pkg::cmd_t   cmd;
  ffba_pkg::seg_t   segs  [MAX_SEGMENTS];
  ffba_pkg::flags_t flags [MAX_SEGMENTS];
  logic [NG*GS-1:0] hits;
  logic             any_split, any_next, any_prev;
  logic [ffba_pkg::BYTE_W-1:0] grant;
  logic             out_free;

  // Row of cells
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    ffba_cell #(
      .IDX(i), .POOL_BYTES(POOL_BYTES), .HEADER_BYTES(HEADER_BYTES)
    ) u_cell (
      .clk(clk), .rst(rst), .cmd(cmd),
      .left (segs[(i == 0) ? 0 : i - 1]),
      .right(segs[(i == MAX_SEGMENTS - 1) ? i : i + 1]),
      .seg(segs[i]), .flags(flags[i])
    );
  end

  // Collect cell status
  always_comb begin
    hits      = '0;
    any_split = 1'b0;
    any_next  = 1'b0;
    any_prev  = 1'b0;
    grant     = '0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      hits[i]   = flags[i].hit;
      any_split = any_split | flags[i].split_ok;
      any_next  = any_next  | flags[i].next_free;
      any_prev  = any_prev  | flags[i].prev_free;
      grant     = grant     | flags[i].grant;
    end
  end

  // First match within each group of cells
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_next[g] = 1'b0;
      grp_idx_next[g] = '0;
      for (int k = GS - 1; k >= 0; k--) begin
        if (hits[g*GS + k]) begin
          grp_any_next[g] = 1'b1;
          grp_idx_next[g] = GW'(k);
        end
      end
    end
  end

  // First group with a match
  always_comb begin
    found_next = 1'b0;
    w_next     = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        found_next = 1'b1;
        w_next     = IW'(g*GS + int'(grp_idx[g]));
      end
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Broadcast command
  always_comb begin
    cmd.act   = ffba_pkg::ACT_NONE;
    cmd.op    = op;
    cmd.req   = req;
    cmd.addr  = addr;
    cmd.w     = ffba_pkg::IDX_W'(w);
    cmd.cnt   = ffba_pkg::CNT_W'(cnt);
    cmd.split = any_split && (cnt < CW'(MAX_SEGMENTS));
    cmd.merge = 1'b0;
    if (state == S_ACT && found) begin
      cmd.act   = (op == ffba_pkg::OP_FREE) ? ffba_pkg::ACT_FREE : ffba_pkg::ACT_ALLOC;
      cmd.merge = any_next;
    end else if (state == S_MERGE) begin
      cmd.act   = ffba_pkg::ACT_MERGE;
      cmd.merge = any_prev;
    end
  end

  // Controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= CW'(1);
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= opcode;
            req   <= request_size;
            addr  <= block_address;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          grp_any <= grp_any_next;
          grp_idx <= grp_idx_next;
          state   <= S_PICK;
        end
        S_PICK: begin
          w     <= w_next;
          found <= found_next;
          if (out_free) state <= S_ACT;
        end
        S_ACT: begin
          out_valid       <= 1'b1;
          success         <= found;
          granted_address <= (found && op == ffba_pkg::OP_ALLOC) ? grant : '0;
          if (found && op == ffba_pkg::OP_ALLOC && cmd.split) cnt <= cnt + 1'b1;
          if (found && op == ffba_pkg::OP_FREE && cmd.merge) cnt <= cnt - 1'b1;
          state <= (found && op == ffba_pkg::OP_FREE) ? S_MERGE : S_IDLE;
        end
        S_MERGE: begin
          if (cmd.merge) cnt <= cnt - 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### test/tb_first_fit_block_allocator_unit.sv
// Self-checking testbench for first_fit_block_allocator_unit.
// Depends on ffba_pkg and the allocator RTL; a segment-table predictor checks each result.
`default_nettype none
module tb_first_fit_block_allocator_unit;

  localparam int unsigned BYTE_W = ffba_pkg::BYTE_W;
  localparam int unsigned POOL = ffba_pkg::DEF_POOL_BYTES;
  localparam int unsigned HDR  = ffba_pkg::DEF_HEADER_BYTES;
  localparam int unsigned MAXS = ffba_pkg::DEF_MAX_SEGMENTS;

  typedef struct {
    int unsigned start;
    int unsigned size;
    bit          is_free;
  } segment_t;

  typedef struct {
    logic              ok;
    logic [BYTE_W-1:0] addr;
  } grant_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              opcode = ffba_pkg::OP_ALLOC;
  logic [BYTE_W-1:0] request_size = '0;
  logic [BYTE_W-1:0] block_address = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              success;
  logic [BYTE_W-1:0] granted_address;

  first_fit_block_allocator_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .request_size(request_size), .block_address(block_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .success(success), .granted_address(granted_address)
  );

  // Predictor state and pending results
  segment_t          pool_map[MAXS];
  int unsigned       seg_total;
  grant_t            pending_grants[$];
  logic [BYTE_W-1:0] live_blocks[$];
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       error_count = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void pool_reset();
    pool_map[0] = '{start: 0, size: POOL - HDR, is_free: 1'b1};
    seg_total = 1;
  endfunction

  // Fold entry j+1 into entry j and close the gap
  function automatic void fold_next(int unsigned j);
    pool_map[j].size = pool_map[j].size + pool_map[j+1].size + HDR;
    for (int unsigned k = j + 1; k + 1 < seg_total; k++) pool_map[k] = pool_map[k+1];
    seg_total--;
  endfunction

  function automatic grant_t predict_grant(logic op, logic [BYTE_W-1:0] req,
                                           logic [BYTE_W-1:0] addr);
    grant_t g;
    int unsigned r;
    g.ok = 1'b0;
    g.addr = '0;
    if (op == ffba_pkg::OP_ALLOC) begin
      for (int unsigned i = 0; i < seg_total; i++) begin
        if (pool_map[i].is_free && pool_map[i].size >= req) begin
          r = pool_map[i].size - req;
          if (r > HDR && seg_total < MAXS) begin
            for (int unsigned k = seg_total; k > i + 1; k--) pool_map[k] = pool_map[k-1];
            pool_map[i+1] = '{start: pool_map[i].start + HDR + req, size: r - HDR,
                              is_free: 1'b1};
            pool_map[i].size = req;
            seg_total++;
          end
          pool_map[i].is_free = 1'b0;
          g.ok = 1'b1;
          g.addr = BYTE_W'(pool_map[i].start + HDR);
          return g;
        end
      end
      return g;
    end
    for (int unsigned i = 0; i < seg_total; i++) begin
      if (pool_map[i].start + HDR == addr) begin
        pool_map[i].is_free = 1'b1;
        if (i + 1 < seg_total && pool_map[i+1].is_free) fold_next(i);
        if (i > 0 && pool_map[i-1].is_free) fold_next(i - 1);
        g.ok = 1'b1;
        return g;
      end
    end
    return g;
  endfunction

  // Send one transaction and record its expected result; valid stays high
  // on return so that a following transaction can go back to back
  task automatic send_request(logic op, logic [BYTE_W-1:0] req, logic [BYTE_W-1:0] addr);
    grant_t g;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    request_size <= req;
    block_address <= addr;
    do @(posedge clk); while (in_stall);
    g = predict_grant(op, req, addr);
    pending_grants.push_back(g);
    if (op == ffba_pkg::OP_ALLOC && g.ok) live_blocks.push_back(g.addr);
    @(negedge clk);
  endtask

  task automatic alloc_block(logic [BYTE_W-1:0] req);
    send_request(ffba_pkg::OP_ALLOC, req, BYTE_W'($urandom));
  endtask

  // Free a random live block, or occasionally an arbitrary address
  task automatic free_some_block();
    int unsigned j;
    if (live_blocks.size() != 0 && $urandom_range(9) != 0) begin
      j = $urandom_range(live_blocks.size() - 1);
      send_request(ffba_pkg::OP_FREE, BYTE_W'($urandom), live_blocks[j]);
      live_blocks.delete(j);
    end else begin
      send_request(ffba_pkg::OP_FREE, BYTE_W'($urandom), BYTE_W'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Receiver: random stall and result check
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    grant_t g;
    if (!rst && out_valid && !out_stall) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected result transaction");
        error_count++;
      end else begin
        g = pending_grants.pop_front();
        if (success !== g.ok) begin
          $error("success: expected %0d, got %0d", g.ok, success);
          error_count++;
        end
        if (granted_address !== g.addr) begin
          $error("granted_address: expected %0d, got %0d", g.addr, granted_address);
          error_count++;
        end
      end
    end
  end

  // Directed: field extremes, zero size, whole pool, failures, double free
  task automatic test_directed();
    alloc_block('0);
    alloc_block(15'd100);
    alloc_block(15'h7FFF);
    alloc_block(15'd200);
    send_request(ffba_pkg::OP_FREE, 15'h7FFF, 15'd40);
    send_request(ffba_pkg::OP_FREE, '0, 15'd40);
    send_request(ffba_pkg::OP_FREE, '0, 15'h7FFF);
    send_request(ffba_pkg::OP_FREE, '0, '0);
    send_request(ffba_pkg::OP_FREE, '0, 15'd180);
    send_request(ffba_pkg::OP_FREE, '0, 15'd80);
    alloc_block(15'd41);
    alloc_block(15'd42);
    alloc_block(15'd81);
    send_request(ffba_pkg::OP_FREE, '0, 15'd80);
    send_request(ffba_pkg::OP_FREE, '0, 15'd161);
    send_request(ffba_pkg::OP_FREE, '0, 15'd40);
    live_blocks.delete();
    alloc_block(BYTE_W'(POOL - HDR));
    alloc_block(15'd1);
    send_request(ffba_pkg::OP_FREE, '0, 15'd40);
    alloc_block(15'h5555);
    alloc_block(15'h2AAA);
    wait_drained();
  endtask

  // Random: mostly well-formed alloc/free traffic with small sizes
  task automatic test_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(1)) begin
        case ($urandom_range(9))
          0: alloc_block(BYTE_W'($urandom));
          1: alloc_block(BYTE_W'($urandom_range(40)));
          default: alloc_block(BYTE_W'($urandom_range(120)));
        endcase
      end else begin
        free_some_block();
      end
    end
    wait_drained();
  endtask

  // Fill the table so allocations stop splitting, then release it all
  task automatic test_table_full();
    for (int unsigned i = 0; i < MAXS + 20; i++) alloc_block(BYTE_W'($urandom_range(8)));
    while (live_blocks.size() != 0) free_some_block();
    wait_drained();
  endtask

  initial begin
    pool_reset();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    send_idle_pct = 26;
    recv_idle_pct = 56;
    test_random(150);
    send_idle_pct = 56;
    recv_idle_pct = 26;
    test_random(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_table_full();
    test_random(100);
    if (error_count == 0) begin
      $display("tb_first_fit_block_allocator_unit: done, clean");
    end else begin
      $display("tb_first_fit_block_allocator_unit: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb_first_fit_block_allocator_unit: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
design/ffba_pkg.sv
design/ffba_cell.sv
design/first_fit_block_allocator_unit.sv
test/tb_first_fit_block_allocator_unit.sv
